// File: src/mwsm_pkg.sv
// shared widths, register codes and types of the mecanum wheel speed mixer
`default_nettype none

package mwsm_pkg;

  // fixed point fraction bits of the Q registers
  localparam int FRAC_BITS = 16;

  localparam int VEL_W      = 16;
  localparam int LIM_W      = 15;
  localparam int Q_REG_W    = 24;
  localparam int NUM_WHEELS = 4;
  localparam int WHEEL_W    = 16;

  localparam int IN_DATA_W  = 3 * VEL_W;
  localparam int OUT_DATA_W = NUM_WHEELS * WHEEL_W;

  // mixing and scaling widths
  localparam int LIN_W       = VEL_W + 2;
  localparam int RATIO_W     = Q_REG_W + 2;
  localparam int PROD_W      = VEL_W + RATIO_W;
  localparam int LIN_SH_W    = LIN_W + FRAC_BITS;
  localparam int SUM_W       = ((PROD_W > LIN_SH_W) ? PROD_W : LIN_SH_W) + 1;
  localparam int SCALE_SPLIT = Q_REG_W / 2;
  localparam int MUL_W       = SUM_W + SCALE_SPLIT;
  localparam int T_W         = MUL_W + 1;
  localparam int T_SHIFT     = 2 * FRAC_BITS - SCALE_SPLIT;

  // wheel magnitude and limiting divider
  localparam int ABS_W = WHEEL_W + 1;
  localparam int NUM_W = ABS_W + LIM_W;
  localparam int DEN_W = ABS_W;
  localparam int QUO_W = LIM_W;

  localparam int WHEEL_POS_MAX = 32767;
  localparam int WHEEL_NEG_MAG = 32768;
  localparam logic [WHEEL_W-1:0] WHEEL_MOST_NEG = 16'h8000;

  // configuration port
  localparam int REG_IDX_W  = 4;
  localparam int CFG_DATA_W = Q_REG_W;

  localparam logic [REG_IDX_W-1:0] REG_FORWARD_LIMIT   = 4'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIDEWAYS_LIMIT  = 4'd1;
  localparam logic [REG_IDX_W-1:0] REG_TURN_LIMIT      = 4'd2;
  localparam logic [REG_IDX_W-1:0] REG_WHEEL_RPM_LIMIT = 4'd3;
  localparam logic [REG_IDX_W-1:0] REG_RPM_SCALE       = 4'd4;
  localparam logic [REG_IDX_W-1:0] REG_ROTATE_BASE     = 4'd5;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_X_TERM   = 4'd6;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y_TERM   = 4'd7;

  localparam logic [LIM_W-1:0]   RST_FORWARD_LIMIT   = 15'd3000;
  localparam logic [LIM_W-1:0]   RST_SIDEWAYS_LIMIT  = 15'd3000;
  localparam logic [LIM_W-1:0]   RST_TURN_LIMIT      = 15'd300;
  localparam logic [LIM_W-1:0]   RST_WHEEL_RPM_LIMIT = 15'd8500;
  localparam logic [Q_REG_W-1:0] RST_RPM_SCALE       = 24'd65536;
  localparam logic [Q_REG_W-1:0] RST_ROTATE_BASE     = 24'd65536;
  localparam logic [Q_REG_W-1:0] RST_OFFSET_TERM     = 24'd0;

  // pipeline depth
  localparam int FRONT_STAGES = 7;
  localparam int PIPE_STAGES  = FRONT_STAGES + QUO_W;

  // what rides alongside the divider
  typedef struct packed {
    logic [NUM_WHEELS-1:0][WHEEL_W-1:0] wheel;
    logic                               resc;
  } side_t;

endpackage

`default_nettype wire

// File: src/mwsm_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module mwsm_div import mwsm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [QUO_W-1:0] quo_o
);

  logic [NUM_W-1:0] rem_q [QUO_W-1];
  logic [DEN_W-1:0] den_q [QUO_W-1];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [NUM_W-1:0] den_sh;
    logic             fits;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign den_sh = NUM_W'(den_in) << (QUO_W - 1 - k);
    assign fits   = (rem_in >= den_sh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= fits ? (quo_in | (QUO_W'(1) << (QUO_W - 1 - k))) : quo_in;
      end
    end

    if (k < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= fits ? (rem_in - den_sh) : rem_in;
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

`default_nettype wire

// File: src/mecanum_wheel_speed_mixer_unit.sv
// an accepted request passes every stage and the output register before tvalid on the result side
// throughput: one request per cycle; a stall on the result side freezes every stage
// depth is set by the 15 stage limiting divider behind 7 mixing and scaling stages
// reset clears all valid bits and returns the config registers to their defaults
`default_nettype none

module mecanum_wheel_speed_mixer_unit import mwsm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // config write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [REG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // request side
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // forward_speed, sideways_speed, turn_rate
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // offset_centre
  input  wire logic [0:0]            s_axis_tuser,
  // result side
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // wheel_front_right, wheel_front_left, wheel_back_left, wheel_back_right
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // rescaled
  output logic [0:0]                 m_axis_tuser
);

  // config registers
  logic [LIM_W-1:0]   fwd_lim_q, side_lim_q, turn_lim_q, rpm_lim_q;
  logic [Q_REG_W-1:0] rpm_scale_q, rot_base_q, off_x_q, off_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_lim_q   <= RST_FORWARD_LIMIT;
      side_lim_q  <= RST_SIDEWAYS_LIMIT;
      turn_lim_q  <= RST_TURN_LIMIT;
      rpm_lim_q   <= RST_WHEEL_RPM_LIMIT;
      rpm_scale_q <= RST_RPM_SCALE;
      rot_base_q  <= RST_ROTATE_BASE;
      off_x_q     <= RST_OFFSET_TERM;
      off_y_q     <= RST_OFFSET_TERM;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FORWARD_LIMIT:   fwd_lim_q   <= cfg_data_i[LIM_W-1:0];
        REG_SIDEWAYS_LIMIT:  side_lim_q  <= cfg_data_i[LIM_W-1:0];
        REG_TURN_LIMIT:      turn_lim_q  <= cfg_data_i[LIM_W-1:0];
        REG_WHEEL_RPM_LIMIT: rpm_lim_q   <= cfg_data_i[LIM_W-1:0];
        REG_RPM_SCALE:       rpm_scale_q <= cfg_data_i;
        REG_ROTATE_BASE:     rot_base_q  <= cfg_data_i;
        REG_OFFSET_X_TERM:   off_x_q     <= cfg_data_i;
        REG_OFFSET_Y_TERM:   off_y_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic                   adv;
  logic                   in_acc;
  logic [PIPE_STAGES-1:0] v_q;
  logic                   out_valid_q;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_acc        = s_axis_tvalid && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v_q         <= {v_q[PIPE_STAGES-2:0], in_acc};
      out_valid_q <= v_q[PIPE_STAGES-1];
    end
  end

  function automatic logic signed [VEL_W-1:0] clamp_sym(
    input logic signed [VEL_W-1:0] v,
    input logic        [LIM_W-1:0] lim
  );
    logic signed [VEL_W-1:0] l;
    logic signed [VEL_W-1:0] r;
    l = signed'({1'b0, lim});
    if (v > l) begin
      r = l;
    end else if (v < -l) begin
      r = -l;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // stage 1: clamp speeds
  logic signed [VEL_W-1:0] vx1_q, vy1_q, vw1_q;
  logic                    off1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vx1_q  <= clamp_sym(signed'(s_axis_tdata[VEL_W-1:0]), fwd_lim_q);
      vy1_q  <= clamp_sym(signed'(s_axis_tdata[2*VEL_W-1:VEL_W]), side_lim_q);
      vw1_q  <= clamp_sym(signed'(s_axis_tdata[3*VEL_W-1:2*VEL_W]), turn_lim_q);
      off1_q <= s_axis_tuser[0];
    end
  end

  // stage 2: linear terms and rotation products
  logic signed [RATIO_W-1:0] rb, ox, oy;
  logic signed [RATIO_W-1:0] ratio [NUM_WHEELS];
  logic signed [LIN_W-1:0]   vxe, vye;
  logic signed [LIN_W-1:0]   lin2_d [NUM_WHEELS];
  logic signed [LIN_W-1:0]   lin2_q [NUM_WHEELS];
  logic signed [PROD_W-1:0]  prod2_d [NUM_WHEELS];
  logic signed [PROD_W-1:0]  prod2_q [NUM_WHEELS];

  always_comb begin
    rb  = signed'({2'b00, rot_base_q});
    ox  = RATIO_W'(signed'(off_x_q));
    oy  = RATIO_W'(signed'(off_y_q));
    vxe = LIN_W'(vx1_q);
    vye = LIN_W'(vy1_q);
    if (off1_q) begin
      ratio[0] = rb - ox + oy;
      ratio[1] = rb - ox - oy;
      ratio[2] = rb + ox - oy;
      ratio[3] = rb + ox + oy;
    end else begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        ratio[i] = rb;
      end
    end
    lin2_d[0] = -vxe - vye;
    lin2_d[1] =  vxe - vye;
    lin2_d[2] =  vxe + vye;
    lin2_d[3] = -vxe + vye;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      prod2_d[i] = PROD_W'(vw1_q) * PROD_W'(ratio[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lin2_q  <= lin2_d;
      prod2_q <= prod2_d;
    end
  end

  // stage 3: sum and magnitude
  logic signed [SUM_W-1:0] sum3 [NUM_WHEELS];
  logic [SUM_W-1:0]        mag3_d [NUM_WHEELS];
  logic [SUM_W-1:0]        mag3_q [NUM_WHEELS];
  logic [NUM_WHEELS-1:0]   neg3_d, neg3_q;

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      sum3[i]   = (SUM_W'(lin2_q[i]) <<< FRAC_BITS) + SUM_W'(prod2_q[i]);
      neg3_d[i] = sum3[i][SUM_W-1];
      mag3_d[i] = neg3_d[i] ? SUM_W'(-sum3[i]) : SUM_W'(sum3[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag3_q <= mag3_d;
      neg3_q <= neg3_d;
    end
  end

  // stage 4: rpm scaling split into two narrower partial products
  logic [MUL_W-1:0]      hi4_q [NUM_WHEELS];
  logic [MUL_W-1:0]      lo4_q [NUM_WHEELS];
  logic [NUM_WHEELS-1:0] neg4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        hi4_q[i] <= MUL_W'(mag3_q[i]) * MUL_W'(rpm_scale_q[Q_REG_W-1:SCALE_SPLIT]);
        lo4_q[i] <= MUL_W'(mag3_q[i]) * MUL_W'(rpm_scale_q[SCALE_SPLIT-1:0]);
      end
      neg4_q <= neg3_q;
    end
  end

  // stage 5: drop fraction bits and saturate
  logic [T_W-1:0]     t5 [NUM_WHEELS];
  logic [ABS_W-1:0]   abs5_d [NUM_WHEELS];
  logic [WHEEL_W-1:0] w5_d [NUM_WHEELS];
  logic [ABS_W-1:0]   abs5_q [NUM_WHEELS];
  logic [WHEEL_W-1:0] w5_q [NUM_WHEELS];

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      t5[i] = (T_W'(hi4_q[i]) + T_W'(lo4_q[i] >> SCALE_SPLIT)) >> T_SHIFT;
      if (neg4_q[i]) begin
        abs5_d[i] = (t5[i] > T_W'(WHEEL_NEG_MAG)) ? ABS_W'(WHEEL_NEG_MAG) : t5[i][ABS_W-1:0];
        w5_d[i]   = WHEEL_W'(ABS_W'(0) - abs5_d[i]);
      end else begin
        abs5_d[i] = (t5[i] > T_W'(WHEEL_POS_MAX)) ? ABS_W'(WHEEL_POS_MAX) : t5[i][ABS_W-1:0];
        w5_d[i]   = abs5_d[i][WHEEL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      abs5_q <= abs5_d;
      w5_q   <= w5_d;
    end
  end

  // stage 6: largest magnitude and limit check
  logic [ABS_W-1:0]   m01, m23, mx6_d;
  logic [ABS_W-1:0]   mx6_q;
  logic               resc6_q;
  logic [ABS_W-1:0]   abs6_q [NUM_WHEELS];
  logic [WHEEL_W-1:0] w6_q [NUM_WHEELS];

  always_comb begin
    m01   = (abs5_q[0] > abs5_q[1]) ? abs5_q[0] : abs5_q[1];
    m23   = (abs5_q[2] > abs5_q[3]) ? abs5_q[2] : abs5_q[3];
    mx6_d = (m01 > m23) ? m01 : m23;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mx6_q   <= mx6_d;
      resc6_q <= (mx6_d > ABS_W'(rpm_lim_q));
      abs6_q  <= abs5_q;
      w6_q    <= w5_q;
    end
  end

  // stage 7: numerators of the proportional limit
  logic [NUM_W-1:0]   num7_q [NUM_WHEELS];
  logic [DEN_W-1:0]   den7_q;
  side_t              side7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        num7_q[i]           <= NUM_W'(abs6_q[i]) * NUM_W'(rpm_lim_q);
        side7_q.wheel[i]    <= w6_q[i];
      end
      den7_q       <= mx6_q;
      side7_q.resc <= resc6_q;
    end
  end

  // divider lanes and the matching sideband delay line
  logic [QUO_W-1:0] quo [NUM_WHEELS];
  side_t            side_q [QUO_W];

  for (genvar i = 0; i < NUM_WHEELS; i++) begin : g_lane
    mwsm_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (num7_q[i]),
      .den_i (den7_q),
      .quo_o (quo[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side7_q;
      for (int k = 1; k < QUO_W; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // output register
  side_t out_d, out_q;

  always_comb begin
    out_d = side_q[QUO_W-1];
    if (side_q[QUO_W-1].resc) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        if (side_q[QUO_W-1].wheel[i][WHEEL_W-1]) begin
          out_d.wheel[i] = WHEEL_W'(0) - WHEEL_W'(quo[i]);
        end else begin
          out_d.wheel[i] = WHEEL_W'(quo[i]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_q.wheel;
  assign m_axis_tuser[0] = out_q.resc;

`ifndef NO_ASSERTIONS
  // a stall freezes the valid bits of every stage
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v_q))
    else $error("pipeline valid bits moved during a stall");

  // a limited wheel is a truncated quotient and never reaches the most negative code
  a_limited_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata[WHEEL_W-1:0] != WHEEL_MOST_NEG) &&
      (m_axis_tdata[2*WHEEL_W-1:WHEEL_W] != WHEEL_MOST_NEG) &&
      (m_axis_tdata[3*WHEEL_W-1:2*WHEEL_W] != WHEEL_MOST_NEG) &&
      (m_axis_tdata[4*WHEEL_W-1:3*WHEEL_W] != WHEEL_MOST_NEG))
    else $error("limited wheel speed out of range");
`endif

endmodule

`default_nettype wire

// File: tb/sv/wheel_speed_checker.sv
// predicts the wheel speeds of each accepted request and compares them with the results
`default_nettype none

module wheel_speed_checker import mwsm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic                  cfg_ready_i,
  input  wire logic [REG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  req_valid_i,
  input  wire logic                  req_ready_i,
  // forward_speed, sideways_speed, turn_rate
  input  wire logic [IN_DATA_W-1:0]  req_data_i,
  // offset_centre
  input  wire logic [0:0]            req_user_i,
  input  wire logic                  res_valid_i,
  input  wire logic                  res_ready_i,
  // wheel_front_right, wheel_front_left, wheel_back_left, wheel_back_right
  input  wire logic [OUT_DATA_W-1:0] res_data_i,
  // rescaled
  input  wire logic [0:0]            res_user_i,
  output int                         mismatch_count_o,
  output int                         outstanding_o
);

  localparam int REPORT_LIMIT = 10;

  logic [LIM_W-1:0]   fwd_limit;
  logic [LIM_W-1:0]   side_limit;
  logic [LIM_W-1:0]   turn_limit;
  logic [LIM_W-1:0]   rpm_limit;
  logic [Q_REG_W-1:0] rpm_scale;
  logic [Q_REG_W-1:0] rotate_base;
  logic [Q_REG_W-1:0] offset_x;
  logic [Q_REG_W-1:0] offset_y;

  side_t expected_wheels_q [$];
  side_t got_wheels;
  side_t want_wheels;
  int    mismatches = 0;
  int    wheel_idx;
  string wheel_label [NUM_WHEELS] = '{"front right", "front left",
                                      "back left", "back right"};

  assign mismatch_count_o = mismatches;

  function automatic longint clamp_speed(logic signed [VEL_W-1:0] raw,
                                         logic [LIM_W-1:0] limit);
    longint v;
    longint lim;
    v   = longint'(raw);
    lim = longint'(limit);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic side_t predict_wheel_speeds(logic [IN_DATA_W-1:0] data,
                                                 logic offset_centre);
    longint      vx, vy, vw, rb, ox, oy, lim, acc, t, peak, mag_w;
    longint      ratio [NUM_WHEELS];
    longint      lin [NUM_WHEELS];
    longint      w [NUM_WHEELS];
    logic [79:0] mag;
    logic [79:0] prod;
    side_t       res;
    int          i;
    vx  = clamp_speed(data[VEL_W-1:0], fwd_limit);
    vy  = clamp_speed(data[2*VEL_W-1:VEL_W], side_limit);
    vw  = clamp_speed(data[3*VEL_W-1:2*VEL_W], turn_limit);
    rb  = longint'(rotate_base);
    ox  = longint'($signed(offset_x));
    oy  = longint'($signed(offset_y));
    lim = longint'(rpm_limit);
    if (offset_centre) begin
      ratio[0] = rb - ox + oy;
      ratio[1] = rb - ox - oy;
      ratio[2] = rb + ox - oy;
      ratio[3] = rb + ox + oy;
    end else begin
      for (i = 0; i < NUM_WHEELS; i++) ratio[i] = rb;
    end
    lin[0] = -vx - vy;
    lin[1] =  vx - vy;
    lin[2] =  vx + vy;
    lin[3] = -vx + vy;
    peak     = 0;
    res.resc = 1'b0;
    for (i = 0; i < NUM_WHEELS; i++) begin
      acc  = (lin[i] <<< FRAC_BITS) + vw * ratio[i];
      mag  = 80'((acc < 0) ? -acc : acc);
      // full product is wider than 64 bits for the largest scale
      prod = mag * 80'(rpm_scale);
      t    = longint'(prod >> (2 * FRAC_BITS));
      if (acc < 0) begin
        w[i] = (t > WHEEL_NEG_MAG) ? -WHEEL_NEG_MAG : -t;
      end else begin
        w[i] = (t > WHEEL_POS_MAX) ? WHEEL_POS_MAX : t;
      end
      mag_w = (w[i] < 0) ? -w[i] : w[i];
      if (mag_w > peak) peak = mag_w;
    end
    // proportional limiting, division truncates toward zero
    if (peak > lim) begin
      res.resc = 1'b1;
      for (i = 0; i < NUM_WHEELS; i++) w[i] = (w[i] * lim) / peak;
    end
    for (i = 0; i < NUM_WHEELS; i++) res.wheel[i] = w[i][WHEEL_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_limit     <= RST_FORWARD_LIMIT;
      side_limit    <= RST_SIDEWAYS_LIMIT;
      turn_limit    <= RST_TURN_LIMIT;
      rpm_limit     <= RST_WHEEL_RPM_LIMIT;
      rpm_scale     <= RST_RPM_SCALE;
      rotate_base   <= RST_ROTATE_BASE;
      offset_x      <= RST_OFFSET_TERM;
      offset_y      <= RST_OFFSET_TERM;
      outstanding_o <= 0;
      expected_wheels_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_FORWARD_LIMIT:   fwd_limit   <= cfg_data_i[LIM_W-1:0];
          REG_SIDEWAYS_LIMIT:  side_limit  <= cfg_data_i[LIM_W-1:0];
          REG_TURN_LIMIT:      turn_limit  <= cfg_data_i[LIM_W-1:0];
          REG_WHEEL_RPM_LIMIT: rpm_limit   <= cfg_data_i[LIM_W-1:0];
          REG_RPM_SCALE:       rpm_scale   <= cfg_data_i;
          REG_ROTATE_BASE:     rotate_base <= cfg_data_i;
          REG_OFFSET_X_TERM:   offset_x    <= cfg_data_i;
          REG_OFFSET_Y_TERM:   offset_y    <= cfg_data_i;
          default: ;
        endcase
      end
      if (req_valid_i && req_ready_i) begin
        expected_wheels_q.push_back(predict_wheel_speeds(req_data_i, req_user_i[0]));
      end
      if (res_valid_i && res_ready_i) begin
        got_wheels.wheel = res_data_i;
        got_wheels.resc  = res_user_i[0];
        if (expected_wheels_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("result with no request outstanding: data %h", res_data_i);
          end
        end else begin
          want_wheels = expected_wheels_q.pop_front();
          for (wheel_idx = 0; wheel_idx < NUM_WHEELS; wheel_idx++) begin
            if (got_wheels.wheel[wheel_idx] !== want_wheels.wheel[wheel_idx]) begin
              mismatches++;
              if (mismatches <= REPORT_LIMIT) begin
                $display("%s wheel mismatch: expected %0d, got %0d",
                         wheel_label[wheel_idx], $signed(want_wheels.wheel[wheel_idx]),
                         $signed(got_wheels.wheel[wheel_idx]));
              end
            end
          end
          if (got_wheels.resc !== want_wheels.resc) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("rescaled flag mismatch: expected %b, got %b",
                       want_wheels.resc, got_wheels.resc);
            end
          end
        end
      end
      outstanding_o <= expected_wheels_q.size();
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/tb_mecanum_wheel_speed_mixer_unit.sv
// testbench top for the mecanum wheel speed mixer: clock, reset, config, requests and verdict
`default_nettype none

module tb_mecanum_wheel_speed_mixer_unit import mwsm_pkg::*; ();

  localparam int CLK_HALF        = 10;
  localparam int RESET_CYCLES    = 7;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 193;
  localparam int HOLD_PHASE      = 3;
  localparam int RX_HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES   = 40;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int MAX_GAP         = 3;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [REG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [0:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  int mismatch_count;
  int outstanding;
  int cur_fwd_lim;
  int cur_side_lim;
  int cur_turn_lim;
  int timeout_cycles;
  int rx_hold_count;
  bit tx_eager = 1'b0;
  bit rx_eager = 1'b0;
  bit rx_hold  = 1'b0;

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  mecanum_wheel_speed_mixer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  wheel_speed_checker mix_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .req_valid_i      (s_axis_tvalid),
    .req_ready_i      (s_axis_tready),
    .req_data_i       (s_axis_tdata),
    .req_user_i       (s_axis_tuser),
    .res_valid_i      (m_axis_tvalid),
    .res_ready_i      (m_axis_tready),
    .res_data_i       (m_axis_tdata),
    .res_user_i       (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic write_all_regs(input logic [CFG_DATA_W-1:0] fwd, side, turn, rpm,
                                input logic [CFG_DATA_W-1:0] scale, base, ox, oy);
    logic [REG_IDX_W-1:0] spare_idx;
    spare_idx = REG_IDX_W'($urandom_range(REG_OFFSET_Y_TERM + 1, (1 << REG_IDX_W) - 1));
    cfg_write(REG_FORWARD_LIMIT, fwd);
    cfg_write(REG_SIDEWAYS_LIMIT, side);
    cfg_write(REG_TURN_LIMIT, turn);
    cfg_write(REG_WHEEL_RPM_LIMIT, rpm);
    cfg_write(REG_RPM_SCALE, scale);
    cfg_write(REG_ROTATE_BASE, base);
    cfg_write(REG_OFFSET_X_TERM, ox);
    cfg_write(REG_OFFSET_Y_TERM, oy);
    // index past the register list must leave everything as it is
    cfg_write(spare_idx, CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;
    cur_fwd_lim  = int'(fwd[LIM_W-1:0]);
    cur_side_lim = int'(side[LIM_W-1:0]);
    cur_turn_lim = int'(turn[LIM_W-1:0]);
  endtask

  task automatic send_request(input logic [VEL_W-1:0] fwd, side, turn, input logic off);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {turn, side, fwd};
    s_axis_tuser  <= off;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] draw_limit(int typical);
    logic [CFG_DATA_W-1:0] data;
    // bits above the limit width stay random, the block must drop them
    data = CFG_DATA_W'($urandom);
    case ($urandom_range(0, 7))
      0:       data[LIM_W-1:0] = '0;
      1:       data[LIM_W-1:0] = '1;
      2, 3, 4: data[LIM_W-1:0] = LIM_W'($urandom_range(0, typical));
      default: ;
    endcase
    return data;
  endfunction

  function automatic logic [Q_REG_W-1:0] draw_q_unsigned();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      2:       return Q_REG_W'(1 << FRAC_BITS);
      3, 4:    return Q_REG_W'($urandom_range(0, 1 << (FRAC_BITS + 2)));
      default: return Q_REG_W'($urandom);
    endcase
  endfunction

  function automatic logic [Q_REG_W-1:0] draw_q_signed();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(Q_REG_W - 1){1'b0}}};
      1:       return {1'b0, {(Q_REG_W - 1){1'b1}}};
      2:       return '0;
      3, 4:    return Q_REG_W'($urandom_range(0, 1 << (FRAC_BITS + 2)) - (1 << (FRAC_BITS + 1)));
      default: return Q_REG_W'($urandom);
    endcase
  endfunction

  function automatic logic [VEL_W-1:0] draw_speed(int span);
    logic [VEL_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = VEL_W'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0:       v = 16'h7FFF;
          1:       v = 16'h8000;
          2:       v = 16'h0000;
          3:       v = 16'h0001;
          default: v = 16'hFFFF;
        endcase
      end
      // mostly spread over the configured limit range, reaching just past it on either side
      default: v = VEL_W'($urandom_range(0, 2 * span + 2) - (span + 1));
    endcase
    return v;
  endfunction

  // result side: random stalls, and a long hold-off when asked
  initial begin
    int stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
        for (rx_hold_count = 0; rx_hold_count < RX_HOLD_CYCLES; rx_hold_count++) begin
          @(posedge clk_i);
        end
        rx_hold = 1'b0;
      end
      stall = rx_eager ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  initial begin
    for (timeout_cycles = 0; timeout_cycles < CYCLE_LIMIT; timeout_cycles++) begin
      @(posedge clk_i);
    end
    $display("tb_mecanum_wheel_speed_mixer_unit: FAIL");
    $finish;
  end

  initial begin
    int phase;
    int n;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults, speeds at and beyond the limits
    send_request(0, 0, 0, 1'b0);
    send_request(16'h7FFF, 0, 0, 1'b0);
    send_request(16'h8000, 0, 0, 1'b1);
    send_request(0, 16'h7FFF, 0, 1'b1);
    send_request(0, 16'h8000, 0, 1'b0);
    send_request(0, 0, 16'h7FFF, 1'b0);
    send_request(0, 0, 16'h8000, 1'b1);
    send_request(3000, 3000, 300, 1'b0);
    send_request(16'(-3000), 3000, 16'(-300), 1'b1);
    send_request(16'h5555, 16'hAAAA, 16'h5555, 1'b1);
    send_request(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
    send_request(1, 16'(-1), 1, 1'b1);
    wait_for_results();

    // zero forward limit, zero rpm limit, junk above the limit width
    write_all_regs(24'hFF8000, 24'hAA81F4, 24'h007FFF, 24'h000000,
                   24'h010000, 24'h010000, 24'hFF0000, 24'h020000);
    send_request(1000, 1000, 100, 1'b1);
    send_request(0, 1, 0, 1'b0);
    send_request(0, 0, 1, 1'b0);
    send_request(16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_request(0, 0, 0, 1'b1);
    wait_for_results();

    // every register at its extreme: saturation and limiting down to one rpm
    write_all_regs(24'h007FFF, 24'h007FFF, 24'h007FFF, 24'h000001,
                   24'hFFFFFF, 24'hFFFFFF, 24'h800000, 24'h7FFFFF);
    send_request(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
    send_request(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_request(16'h8000, 16'h7FFF, 16'h8000, 1'b1);
    send_request(0, 0, 0, 1'b0);
    send_request(1, 0, 0, 1'b0);
    send_request(0, 16'hFFFF, 16'hFFFF, 1'b1);
    wait_for_results();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_all_regs(draw_limit(4000), draw_limit(4000), draw_limit(400), draw_limit(10000),
                     draw_q_unsigned(), draw_q_unsigned(), draw_q_signed(), draw_q_signed());
      tx_eager = (phase == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
      rx_eager = ($urandom_range(0, 3) == 0);
      // sender keeps offering while results back up behind the hold-off
      if (phase == HOLD_PHASE) rx_hold = 1'b1;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_request(draw_speed(cur_fwd_lim), draw_speed(cur_side_lim),
                     draw_speed(cur_turn_lim), 1'($urandom_range(0, 1)));
      end
      wait_for_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("tb_mecanum_wheel_speed_mixer_unit: PASS");
    end else begin
      $display("tb_mecanum_wheel_speed_mixer_unit: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
src/mwsm_pkg.sv
src/mwsm_div.sv
src/mecanum_wheel_speed_mixer_unit.sv
tb/sv/wheel_speed_checker.sv
tb/sv/tb_mecanum_wheel_speed_mixer_unit.sv
